FILE: src/volume_ray_compositor_defines.svh
// Assertion macros for the ray compositor. Each expects clk and rst in scope.
`ifndef VOLUME_RAY_COMPOSITOR_DEFINES_SVH
`define VOLUME_RAY_COMPOSITOR_DEFINES_SVH

// Condition must hold at every edge outside reset
`define VRC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define VRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define VRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/vrc_pkg.sv
`default_nettype none

package vrc_pkg;

  // Fixed-point constants (opacity Q1.16, shading Q2.14)
  localparam logic [16:0] OPAQUE_ONE        = 17'd65536;
  localparam logic [15:0] SHADE_ONE         = 16'd16384;
  localparam logic [16:0] SHADE_MIN_ALPHA   = 17'd13108;
  localparam logic [16:0] TERMINATE_OPACITY = 17'd65279;
  localparam logic [23:0] COLOR_ACC_MAX     = 24'hFFFFFF;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CUTOFF     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CUTOFF_INV = 2'd2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef struct packed {
    logic        sample_valid;
    logic [7:0]  color_red;
    logic [7:0]  color_green;
    logic [7:0]  color_blue;
    logic [16:0] alpha;
    logic [23:0] sample_weight;
    logic [15:0] shading;
    logic        ray_end;
    logic [7:0]  background_red;
    logic [7:0]  background_green;
    logic [7:0]  background_blue;
  } vrc_sample_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } vrc_pixel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FACTOR,
    ST_SCALE,
    ST_SQUARE,
    ST_REMAIN,
    ST_SHADE,
    ST_ACCUM,
    ST_BACK,
    ST_EMIT
  } vrc_state_t;

  // One step of the datapath per bit, at most one high per cycle
  typedef struct packed {
    logic load;
    logic factor;
    logic scale;
    logic square;
    logic remain;
    logic shade;
    logic accum;
    logic back;
    logic emit;
  } vrc_cmd_t;

  typedef struct packed {
    logic hit;       // incoming beat adds to the ray
    logic scale;     // incoming beat needs the weight cutoff
    logic last_now;  // incoming beat closes the ray
    logic last_held; // held beat closes the ray
    logic out_busy;  // pixel register full and stalled
  } vrc_status_t;

  // Add to a colour accumulator, saturating at its maximum
  function automatic logic [23:0] sat_add(input logic [23:0] acc, input logic [24:0] add);
    logic [25:0] s;
    s = {2'b00, acc} + {1'b0, add};
    sat_add = (s > {2'b00, COLOR_ACC_MAX}) ? COLOR_ACC_MAX : s[23:0];
  endfunction

  // Integer part of a Q10.14 accumulator, saturated at 255
  function automatic logic [7:0] to_pixel(input logic [23:0] acc);
    to_pixel = (acc[23:22] != 2'b00) ? 8'hFF : acc[21:14];
  endfunction

endpackage

`default_nettype wire

FILE: src/vrc_ctrl.sv
`default_nettype none

module vrc_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  samp_valid,
  output logic                 samp_stall,
  input  vrc_pkg::vrc_status_t status,
  output vrc_pkg::vrc_cmd_t    cmd
);
  import vrc_pkg::*;

  vrc_state_t state;
  vrc_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (samp_valid) begin
          if (status.hit) begin
            state_next = status.scale ? ST_FACTOR : ST_SQUARE;
          end else if (status.last_now) begin
            state_next = ST_BACK;
          end
        end
      end
      ST_FACTOR: state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_REMAIN;
      ST_REMAIN: state_next = ST_SHADE;
      ST_SHADE:  state_next = ST_ACCUM;
      ST_ACCUM:  state_next = status.last_held ? ST_BACK : ST_IDLE;
      ST_BACK:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd        = '0;
    samp_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        samp_stall = 1'b0;
        cmd.load   = samp_valid;
      end
      ST_FACTOR: cmd.factor = 1'b1;
      ST_SCALE:  cmd.scale  = 1'b1;
      ST_SQUARE: cmd.square = 1'b1;
      ST_REMAIN: cmd.remain = 1'b1;
      ST_SHADE:  cmd.shade  = 1'b1;
      ST_ACCUM:  cmd.accum  = 1'b1;
      ST_BACK:   cmd.back   = 1'b1;
      ST_EMIT:   cmd.emit   = !status.out_busy;
      default:   cmd        = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/vrc_datapath.sv
`default_nettype none

module vrc_datapath (
  input  wire                                clk,
  input  wire                                rst,
  input  vrc_pkg::vrc_sample_t               samp,
  output vrc_pkg::vrc_pixel_t                pix,
  output logic                               pix_valid,
  input  wire                                pix_stall,
  input  wire                                cfg_write,
  input  wire [vrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [vrc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  vrc_pkg::vrc_cmd_t                  cmd,
  output vrc_pkg::vrc_status_t               status
);
  import vrc_pkg::*;

  // Configuration
  logic        weight_enable;
  logic [23:0] weight_cutoff;
  logic [31:0] weight_cutoff_inv;

  // Held beat and intermediate results
  vrc_sample_t held;
  logic [16:0] alpha_held;
  logic        low_alpha;
  logic [16:0] factor;
  logic [16:0] opa_t;
  logic [16:0] sop;
  logic [16:0] delta;
  logic [18:0] contrib;

  // Ray state
  logic [16:0] acc_opacity;
  logic [23:0] acc_red;
  logic [23:0] acc_green;
  logic [23:0] acc_blue;
  logic        ray_saturated;

  // Combinational terms
  logic [16:0] alpha_in;
  logic [55:0] factor_prod;
  logic [39:0] factor_raw;
  logic [33:0] scale_prod;
  logic [33:0] square_prod;
  logic [16:0] remain;
  logic [33:0] remain_prod;
  logic [15:0] shade_eff;
  logic [32:0] shade_prod;
  logic [26:0] red_prod;
  logic [26:0] green_prod;
  logic [26:0] blue_prod;
  logic [17:0] opa_sum;
  logic [16:0] opa_new;
  logic [24:0] bg_red_prod;
  logic [24:0] bg_green_prod;
  logic [24:0] bg_blue_prod;

  // Clamp incoming opacity to one
  assign alpha_in = (samp.alpha > OPAQUE_ONE) ? OPAQUE_ONE : samp.alpha;

  assign status.hit      = samp.sample_valid && !ray_saturated && (alpha_in != 17'd0);
  assign status.scale    = weight_enable && (samp.sample_weight < weight_cutoff);
  assign status.last_now = samp.ray_end;
  assign status.last_held = held.ray_end;
  assign status.out_busy = pix_valid && pix_stall;

  assign factor_prod = {8'd0, held.sample_weight} * {24'd0, weight_cutoff_inv};
  assign factor_raw  = factor_prod[55:16];
  assign scale_prod  = {17'd0, alpha_held} * {17'd0, factor};
  assign square_prod = {17'd0, opa_t} * {17'd0, opa_t};
  assign remain      = OPAQUE_ONE - acc_opacity;
  assign remain_prod = {17'd0, remain} * {17'd0, sop};
  assign shade_eff   = low_alpha ? SHADE_ONE : held.shading;
  assign shade_prod  = {16'd0, delta} * {17'd0, shade_eff};
  assign red_prod    = {8'd0, contrib} * {19'd0, held.color_red};
  assign green_prod  = {8'd0, contrib} * {19'd0, held.color_green};
  assign blue_prod   = {8'd0, contrib} * {19'd0, held.color_blue};
  assign opa_sum     = {1'b0, acc_opacity} + {1'b0, delta};
  assign opa_new     = (opa_sum > {1'b0, OPAQUE_ONE}) ? OPAQUE_ONE : opa_sum[16:0];
  assign bg_red_prod   = {8'd0, remain} * {17'd0, held.background_red};
  assign bg_green_prod = {8'd0, remain} * {17'd0, held.background_green};
  assign bg_blue_prod  = {8'd0, remain} * {17'd0, held.background_blue};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_enable     <= 1'b0;
      weight_cutoff     <= '0;
      weight_cutoff_inv <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WEIGHT_ENABLE:     weight_enable     <= cfg_data[0];
        CFG_WEIGHT_CUTOFF:     weight_cutoff     <= cfg_data[23:0];
        CFG_WEIGHT_CUTOFF_INV: weight_cutoff_inv <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-sample pipeline of the opacity and contribution terms
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held       <= samp;
      alpha_held <= alpha_in;
      low_alpha  <= alpha_in < SHADE_MIN_ALPHA;
      opa_t      <= alpha_in;
    end
    if (cmd.factor) begin
      factor <= (factor_raw > {23'd0, OPAQUE_ONE}) ? OPAQUE_ONE : factor_raw[16:0];
    end
    if (cmd.scale) begin
      opa_t <= scale_prod[32:16];
    end
    if (cmd.square) begin
      sop <= square_prod[32:16];
    end
    if (cmd.remain) begin
      delta <= remain_prod[32:16];
    end
    if (cmd.shade) begin
      contrib <= shade_prod[32:14];
    end
  end

  // Accumulate, blend background, clear when the pixel is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_opacity   <= '0;
      acc_red       <= '0;
      acc_green     <= '0;
      acc_blue      <= '0;
      ray_saturated <= 1'b0;
    end else if (cmd.accum) begin
      acc_red       <= sat_add(acc_red, red_prod[26:2]);
      acc_green     <= sat_add(acc_green, green_prod[26:2]);
      acc_blue      <= sat_add(acc_blue, blue_prod[26:2]);
      acc_opacity   <= opa_new;
      ray_saturated <= opa_new >= TERMINATE_OPACITY;
    end else if (cmd.back) begin
      if (!ray_saturated) begin
        acc_red   <= sat_add(acc_red, {3'd0, bg_red_prod[23:16], 14'd0});
        acc_green <= sat_add(acc_green, {3'd0, bg_green_prod[23:16], 14'd0});
        acc_blue  <= sat_add(acc_blue, {3'd0, bg_blue_prod[23:16], 14'd0});
      end
    end else if (cmd.emit) begin
      acc_opacity   <= '0;
      acc_red       <= '0;
      acc_green     <= '0;
      acc_blue      <= '0;
      ray_saturated <= 1'b0;
    end
  end

  // Pixel register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (cmd.emit) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pix.pixel_red   <= to_pixel(acc_red);
      pix.pixel_green <= to_pixel(acc_green);
      pix.pixel_blue  <= to_pixel(acc_blue);
    end
  end

endmodule

`default_nettype wire

FILE: src/volume_ray_compositor.sv
// Front-to-back compositor for one ray at a time.
// Sample channel: samp_valid / samp_stall carry one classified sample per beat;
// a beat with ray_end set closes the ray. Pixel channel: pix_valid / pix_stall
// carry one composited RGB pixel per ray, held in an output register.
// Configuration: cfg_write with cfg_index and cfg_data writes one register in
// a cycle; write only while no ray sample is in flight.
// Sequence per sample beat: a beat that adds nothing is taken in idle; an
// adding beat runs the square, remain, shade and accumulate steps, after the
// factor and scale steps when the weight cutoff applies. A closing beat then
// runs background blend and pixel load; pix_valid rises the cycle after it.
// A new sample beat is taken once the sequence is back in idle, even while
// the pixel register still waits. If the pixel register is stalled when the
// next ray closes, the block holds in its load step until the pixel leaves.
// Reset (rst, synchronous) clears the configuration, the running colour and
// opacity, and the pixel valid flag.
`default_nettype none

module volume_ray_compositor (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           samp_valid,
  output logic                          samp_stall,
  input  vrc_pkg::vrc_sample_t          samp,
  output logic                          pix_valid,
  input  wire                           pix_stall,
  output vrc_pkg::vrc_pixel_t           pix,
  input  wire                           cfg_write,
  input  wire [vrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [vrc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vrc_pkg::*;

`include "volume_ray_compositor_defines.svh"

  vrc_cmd_t    cmd;
  vrc_status_t status;

  vrc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .samp_valid (samp_valid),
    .samp_stall (samp_stall),
    .status     (status),
    .cmd        (cmd)
  );

  vrc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .samp      (samp),
    .pix       (pix),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

  // Check the sequencing between controller and datapath
  `VRC_ASSERT_ALWAYS(a_one_cmd, $onehot0(cmd), "more than one datapath step in a cycle")
  `VRC_ASSERT_SAME(a_no_overwrite, cmd.emit, !status.out_busy, "pixel overwritten while stalled")
  `VRC_ASSERT_NEXT(a_emit_shows, cmd.emit, pix_valid, "loaded pixel not presented")
  `VRC_ASSERT_SAME(a_accum_order, cmd.accum, $past(cmd.shade), "accumulate without shade step")

endmodule

`default_nettype wire
